/* hw/rtl/b64_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3d;
   localparam logic       MODE_ENCODE = 1'b0;
   localparam logic       MODE_DECODE = 1'b1;

   // one queued job: up to four result bytes, emitted from index 0 to last_idx
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            last;
      logic            error;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] sym_of(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         r = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         r = 8'h2b;
      end else begin
         r = 8'h2f;
      end
      return r;
   endfunction

   function automatic logic [5:0] six_of(input logic [7:0] c);
      logic [5:0] r;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         r = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin
         r = 6'd62;
      end else if (c == 8'h2f) begin
         r = 6'd63;
      end else begin
         r = 6'd0;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/base64_codec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec
// Streaming base64 encoder/decoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  req      | req_valid / req_stall   | req_data_in[7:0], req_last_in
//  rsp      | rsp_valid / rsp_stall   | rsp_data_out[7:0], rsp_last_out, rsp_error
//  csr      | csr_valid / csr_ready   | csr_mode
//
// one input transaction per cycle while the job queue has room
// results leave one per cycle from the back sequencer unless rsp_stall holds them:
// 4 per encoded group, 1 to 3 per decoded group
// synchronous reset clears mode, group state, queue, output valid and byte index
// rsp_stall holds the output register; the queue fills, then req_stall rises
// ----------------------------------------------------------------------------
module base64_codec #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_in,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_out,
   output logic       rsp_last_out,
   output logic       rsp_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_mode
);

   b64_pkg::queue_status_type q_status;
   b64_pkg::job_type          push_job;
   b64_pkg::job_type          head_job;
   logic                      push;
   logic                      pop;

   b64_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data_in (req_data_in),
      .req_last_in (req_last_in),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_mode    (csr_mode),
      .q_status    (q_status),
      .push        (push),
      .push_job    (push_job)
   );

   b64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   b64_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_out (rsp_data_out),
      .rsp_last_out (rsp_last_out),
      .rsp_error    (rsp_error)
   );

endmodule

/* hw/rtl/b64_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_front
// Accepts input transactions, gathers groups and pushes result jobs.
// ----------------------------------------------------------------------------
module b64_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_in,
   input  logic                      req_last_in,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_mode,
   input  b64_pkg::queue_status_type q_status,
   output logic                      push,
   output b64_pkg::job_type          push_job
);

   logic        mode_ff, mode_in;
   logic [17:0] bits_ff, bits_in;
   logic [1:0]  count_ff, count_in;
   logic [1:0]  pad_ff, pad_in;

   logic        accept;
   logic        job_valid;
   logic [1:0]  pad_n;
   logic [23:0] dec_bits;
   logic [23:0] enc_bits;
   logic [15:0] enc_pair;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept && job_valid;

   assign enc_bits = {bits_ff[15:0], req_data_in};
   assign enc_pair = {bits_ff[7:0], req_data_in};
   assign pad_n    = (req_data_in == b64_pkg::PAD_CHAR && pad_ff < 2'd2) ?
                     pad_ff + 2'd1 : pad_ff;
   assign dec_bits = {bits_ff, b64_pkg::six_of(req_data_in)};

   always_comb begin
      job_valid = 1'b0;
      push_job  = '0;
      bits_in   = bits_ff;
      count_in  = count_ff;
      pad_in    = pad_ff;
      mode_in   = mode_ff;
      if (csr_valid) begin
         mode_in  = csr_mode;
         bits_in  = '0;
         count_in = '0;
         pad_in   = '0;
      end else if (accept) begin
         case (mode_ff)
            b64_pkg::MODE_ENCODE: begin
               if (count_ff == 2'd2) begin
                  job_valid         = 1'b1;
                  push_job.bytes[0] = b64_pkg::sym_of(enc_bits[23:18]);
                  push_job.bytes[1] = b64_pkg::sym_of(enc_bits[17:12]);
                  push_job.bytes[2] = b64_pkg::sym_of(enc_bits[11:6]);
                  push_job.bytes[3] = b64_pkg::sym_of(enc_bits[5:0]);
                  push_job.last_idx = 2'd3;
                  push_job.last     = req_last_in;
                  bits_in  = '0;
                  count_in = '0;
                  pad_in   = '0;
               end else if (req_last_in) begin
                  job_valid = 1'b1;
                  if (count_ff == 2'd0) begin
                     push_job.bytes[0] = b64_pkg::sym_of(req_data_in[7:2]);
                     push_job.bytes[1] = b64_pkg::sym_of({req_data_in[1:0], 4'd0});
                     push_job.bytes[2] = b64_pkg::PAD_CHAR;
                  end else begin
                     push_job.bytes[0] = b64_pkg::sym_of(enc_pair[15:10]);
                     push_job.bytes[1] = b64_pkg::sym_of(enc_pair[9:4]);
                     push_job.bytes[2] = b64_pkg::sym_of({enc_pair[3:0], 2'd0});
                  end
                  push_job.bytes[3] = b64_pkg::PAD_CHAR;
                  push_job.last_idx = 2'd3;
                  push_job.last     = 1'b1;
                  bits_in  = '0;
                  count_in = '0;
                  pad_in   = '0;
               end else begin
                  bits_in  = enc_bits[17:0];
                  count_in = count_ff + 2'd1;
               end
            end
            b64_pkg::MODE_DECODE: begin
               if (count_ff == 2'd3) begin
                  job_valid         = 1'b1;
                  push_job.bytes[0] = dec_bits[23:16];
                  push_job.bytes[1] = dec_bits[15:8];
                  push_job.bytes[2] = dec_bits[7:0];
                  push_job.last_idx = 2'd2 - pad_n;
                  push_job.last     = req_last_in;
                  bits_in  = '0;
                  count_in = '0;
                  pad_in   = '0;
               end else if (req_last_in) begin
                  job_valid         = 1'b1;
                  push_job.last_idx = 2'd0;
                  push_job.last     = 1'b1;
                  push_job.error    = 1'b1;
                  bits_in  = '0;
                  count_in = '0;
                  pad_in   = '0;
               end else begin
                  bits_in  = dec_bits[17:0];
                  count_in = count_ff + 2'd1;
                  pad_in   = pad_n;
               end
            end
            default: begin
               job_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= b64_pkg::MODE_ENCODE;
         bits_ff  <= '0;
         count_ff <= '0;
         pad_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         bits_ff  <= bits_in;
         count_ff <= count_in;
         pad_ff   <= pad_in;
      end
   end

endmodule

/* hw/rtl/b64_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  b64_pkg::job_type          push_job,
   input  logic                      pop,
   output b64_pkg::job_type          head_job,
   output b64_pkg::queue_status_type q_status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push  = push && !q_status.full;
   assign do_pop   = pop && !q_status.empty;
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/b64_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_back
// Walks the head job and emits one result transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64_back (
   input  logic                      clock,
   input  logic                      reset,
   input  b64_pkg::job_type          head_job,
   input  b64_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_data_out,
   output logic                      rsp_last_out,
   output logic                      rsp_error
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       error_ff, error_in;
   logic [1:0] idx_ff, idx_in;
   logic       advance;
   logic       at_end;

   assign advance = !valid_ff || !rsp_stall;
   assign at_end  = (idx_ff == head_job.last_idx);
   assign pop     = advance && !q_status.empty && at_end;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      error_in = error_ff;
      idx_in   = idx_ff;
      if (advance) begin
         valid_in = !q_status.empty;
         data_in  = head_job.bytes[idx_ff];
         last_in  = head_job.last && at_end;
         error_in = head_job.error;
         if (!q_status.empty) begin
            idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      last_ff  <= last_in;
      error_ff <= error_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_data_out = data_ff;
   assign rsp_last_out = last_ff;
   assign rsp_error    = error_ff;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the base64 codec. Byte and character streams are
// driven in encode and decode mode and every result transaction is compared
// with a cycle-free behavioral predictor of the codec. Covers padding,
// characters outside the alphabet, short decode streams and mode changes.
// ----------------------------------------------------------------------------
module tb;

   localparam int    CLK_HALF      = 6;
   localparam int    SETTLE_CYCLES = 8;
   localparam int    TAIL_CYCLES   = 20;
   localparam int    STALL_LIMIT   = 4000;
   localparam int    RANDOM_ITEMS  = 250;
   localparam string ALPHABET      =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } b64_result_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_in;
   logic       req_last_in;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_data_out;
   logic       rsp_last_out;
   logic       rsp_error;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_mode;

   // predictor state
   logic           cur_mode;
   logic [23:0]    gathered_bits;
   int             gathered_count;
   int             pad_seen;
   b64_result_type expected_results[$];

   logic [7:0] stream_buf[$];
   int         mismatches   = 0;
   int         sent_items   = 0;
   int         burst_left   = 0;
   bit         idle_on      = 1'b0;
   int         stall_style  = 0;
   int         stall_run    = 0;
   logic       stall_phase  = 1'b0;
   int         quiet_cycles = 0;

   base64_codec dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data_in  (req_data_in),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_out (rsp_data_out),
      .rsp_last_out (rsp_last_out),
      .rsp_error    (rsp_error),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_mode     (csr_mode)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic logic [7:0] char_for_six(input logic [5:0] v);
      return ALPHABET[v];
   endfunction

   function automatic logic [5:0] six_for_char(input logic [7:0] c);
      logic [5:0] v;
      v = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (ALPHABET[i] == c) begin
            v = 6'(i);
         end
      end
      return v;
   endfunction

   function automatic void push_expected(input logic [7:0] d, input logic l, input logic e);
      b64_result_type r;
      r.data = d;
      r.last = l;
      r.err  = e;
      expected_results.push_back(r);
   endfunction

   function automatic void clear_group();
      gathered_bits  = 24'd0;
      gathered_count = 0;
      pad_seen       = 0;
   endfunction

   function automatic void predict_codec(input logic [7:0] d, input logic l);
      int n;
      if (cur_mode == b64_pkg::MODE_ENCODE) begin
         gathered_bits = {gathered_bits[15:0], d};
         gathered_count++;
         if (gathered_count == 3) begin
            push_expected(char_for_six(gathered_bits[23:18]), 1'b0, 1'b0);
            push_expected(char_for_six(gathered_bits[17:12]), 1'b0, 1'b0);
            push_expected(char_for_six(gathered_bits[11:6]), 1'b0, 1'b0);
            push_expected(char_for_six(gathered_bits[5:0]), l, 1'b0);
            clear_group();
         end else if (l) begin
            if (gathered_count == 1) begin
               push_expected(char_for_six(gathered_bits[7:2]), 1'b0, 1'b0);
               push_expected(char_for_six({gathered_bits[1:0], 4'b0000}), 1'b0, 1'b0);
               push_expected(b64_pkg::PAD_CHAR, 1'b0, 1'b0);
            end else begin
               push_expected(char_for_six(gathered_bits[15:10]), 1'b0, 1'b0);
               push_expected(char_for_six(gathered_bits[9:4]), 1'b0, 1'b0);
               push_expected(char_for_six({gathered_bits[3:0], 2'b00}), 1'b0, 1'b0);
            end
            push_expected(b64_pkg::PAD_CHAR, 1'b1, 1'b0);
            clear_group();
         end
      end else begin
         if (d == b64_pkg::PAD_CHAR && pad_seen < 2) begin
            pad_seen++;
         end
         gathered_bits = {gathered_bits[17:0], six_for_char(d)};
         gathered_count++;
         if (gathered_count == 4) begin
            n = 3 - pad_seen;
            for (int k = 0; k < n; k++) begin
               push_expected(8'(gathered_bits >> (16 - 8 * k)), (k == n - 1) ? l : 1'b0, 1'b0);
            end
            clear_group();
         end else if (l) begin
            push_expected(8'h00, 1'b1, 1'b1);
            clear_group();
         end
      end
   endfunction

   // receiver stall pattern: none, or alternating runs of random length
   always @(negedge clock) begin
      if (stall_style == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run == 0) begin
            stall_phase = ~stall_phase;
            stall_run = stall_phase ? $urandom_range(1, (stall_style == 2) ? 20 : 3)
                                    : $urandom_range(1, 10);
         end
         stall_run--;
         rsp_stall <= stall_phase;
      end
   end

   // result checker
   always @(posedge clock) begin
      b64_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected transaction: data %h last %b error %b",
                        rsp_data_out, rsp_last_out, rsp_error);
            end
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_data_out !== exp_r.data || rsp_last_out !== exp_r.last ||
                rsp_error !== exp_r.err) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: data exp %h got %h, last exp %b got %b, error exp %b got %b",
                           exp_r.data, rsp_data_out, exp_r.last, rsp_last_out,
                           exp_r.err, rsp_error);
               end
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [7:0] d, input logic l);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = idle_on ? $urandom_range(0, 6) : 0;
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_data_in <= d;
      req_last_in <= l;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_codec(d, l);
      sent_items++;
   endtask

   task automatic send_stream(input logic mark_last);
      for (int i = 0; i < stream_buf.size(); i++) begin
         send_item(stream_buf[i], mark_last && (i == stream_buf.size() - 1));
      end
      stream_buf.delete();
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_mode  <= m;
      do @(posedge clock); while (!csr_ready);
      cur_mode = m;
      clear_group();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_encode_basics();
      write_mode(b64_pkg::MODE_ENCODE);
      stream_buf = '{8'h00, 8'hff, 8'h5a};
      send_stream(1'b0);
      stream_buf = '{8'hff};
      send_stream(1'b1);
      stream_buf = '{8'h00, 8'h81};
      send_stream(1'b1);
   endtask

   task automatic test_decode_basics();
      write_mode(b64_pkg::MODE_DECODE);
      // plus, slash and characters outside the alphabet
      stream_buf = '{8'h2b, 8'hff, 8'h2a, 8'h2f};
      send_stream(1'b0);
      // padding in the middle of a group
      stream_buf = '{8'h41, b64_pkg::PAD_CHAR, 8'h7a, b64_pkg::PAD_CHAR};
      send_stream(1'b1);
      // pad count saturates, zero byte is still emitted
      stream_buf = '{b64_pkg::PAD_CHAR, b64_pkg::PAD_CHAR, b64_pkg::PAD_CHAR, 8'h39};
      send_stream(1'b0);
      // stream ends mid-group
      stream_buf = '{8'h5a, 8'h30};
      send_stream(1'b1);
   endtask

   task automatic test_mode_writes();
      write_mode(b64_pkg::MODE_DECODE);
      stream_buf = '{8'h54, 8'h57};
      send_stream(1'b0);
      write_mode(b64_pkg::MODE_DECODE);
      stream_buf = '{8'h54, 8'h57, 8'h46, 8'h75};
      send_stream(1'b1);
      write_mode(b64_pkg::MODE_ENCODE);
      stream_buf = '{8'h12, 8'h34};
      send_stream(1'b0);
      write_mode(b64_pkg::MODE_ENCODE);
      stream_buf = '{8'h80};
      send_stream(1'b1);
      write_mode(b64_pkg::MODE_DECODE);
      stream_buf = '{8'h61};
      send_stream(1'b0);
      write_mode(b64_pkg::MODE_ENCODE);
      stream_buf = '{8'hc3};
      send_stream(1'b1);
   endtask

   task automatic test_encode_random();
      int goal;
      int streams;
      int len;
      write_mode(b64_pkg::MODE_ENCODE);
      goal = sent_items + RANDOM_ITEMS;
      streams = 0;
      while (sent_items < goal) begin
         idle_on     = (streams % 20) < 14;
         stall_style = (streams / 10) % 3;
         len = $urandom_range(1, 10);
         for (int i = 0; i < len; i++) begin
            stream_buf.push_back(8'($urandom_range(0, 255)));
         end
         send_stream($urandom_range(0, 7) != 0);
         streams++;
         if (streams % 25 == 0) begin
            wait_for_results();
         end
      end
   endtask

   task automatic test_decode_random();
      int goal;
      int streams;
      int kind;
      int groups;
      int pads;
      int cut;
      write_mode(b64_pkg::MODE_DECODE);
      goal = sent_items + RANDOM_ITEMS;
      streams = 0;
      while (sent_items < goal) begin
         idle_on     = (streams % 20) >= 6;
         stall_style = (streams / 10) % 3;
         kind = $urandom_range(0, 9);
         if (kind == 7) begin
            // noise, any character code, frequent padding
            repeat ($urandom_range(1, 8)) begin
               stream_buf.push_back(($urandom_range(0, 3) == 0) ? b64_pkg::PAD_CHAR
                                                                : 8'($urandom_range(0, 255)));
            end
         end else begin
            groups = $urandom_range(1, 3);
            repeat (4 * groups) begin
               stream_buf.push_back(char_for_six(6'($urandom_range(0, 63))));
            end
            pads = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
            for (int i = 0; i < pads; i++) begin
               stream_buf[stream_buf.size() - 1 - i] = b64_pkg::PAD_CHAR;
            end
            if (kind == 8) begin
               cut = $urandom_range(1, 3);
               repeat (cut) void'(stream_buf.pop_back());
            end else if (kind == 9) begin
               stream_buf[$urandom_range(0, stream_buf.size() - 1)] = b64_pkg::PAD_CHAR;
            end
         end
         send_stream(kind != 6);
         streams++;
         if (streams % 25 == 0) begin
            wait_for_results();
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data_in = 8'h00;
      req_last_in = 1'b0;
      csr_valid   = 1'b0;
      csr_mode    = b64_pkg::MODE_ENCODE;
      cur_mode    = b64_pkg::MODE_ENCODE;
      clear_group();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_encode_basics();
      test_decode_basics();
      test_mode_writes();
      test_encode_random();
      test_decode_random();

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* base64_codec.f */
hw/rtl/b64_pkg.sv
hw/rtl/b64_front.sv
hw/rtl/b64_queue.sv
hw/rtl/b64_back.sv
hw/rtl/base64_codec.sv
tb/tb.sv
